// ===== rtl/sfla_pkg.sv =====
// sfla_pkg: shared types, codes and the control store for the slot free list allocator
// depends on nothing; imported by sfla_link_ram, sfla_sequencer and slot_free_list_allocator
`timescale 1ns / 1ps

package sfla_pkg;

   localparam int LINK_W    = 6;
   localparam int COUNT_W   = 7;
   localparam int LINK_SPAN = 64;
   localparam int CSR_W     = 32;
   localparam int CSR_AW    = 3;

   typedef logic [LINK_W-1:0]  link_type;
   typedef logic [COUNT_W-1:0] count_type;

   // register index, taken from the word address bit of the csr port
   localparam logic REG_SLOT_COUNT = 1'b0;
   localparam count_type SLOT_COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_INIT  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_BAD_SLOT = 2'd2
   } status_type;

   // control store addresses
   typedef enum logic [3:0] {
      S_IDLE    = 4'd0,
      S_A_CHK   = 4'd1,
      S_A_LINK  = 4'd2,
      S_A_TAIL  = 4'd3,
      S_F_CHK   = 4'd4,
      S_F_TEST  = 4'd5,
      S_F_LINK1 = 4'd6,
      S_F_LINK2 = 4'd7,
      S_F_SOLO  = 4'd8,
      S_I_LOOP  = 4'd9,
      S_I_DONE  = 4'd10,
      S_R_EMPTY = 4'd11,
      S_R_BAD   = 4'd12,
      S_R_OK    = 4'd13
   } step_type;

   typedef enum logic [1:0] {
      COND_NONE      = 2'd0,
      COND_TAIL_ZERO = 2'd1,
      COND_BAD_SLOT  = 2'd2,
      COND_LOOP_MORE = 2'd3
   } cond_type;

   // next link table write select
   typedef enum logic [2:0] {
      NW_NONE      = 3'd0,
      NW_UNLINK    = 3'd1,
      NW_RING_END  = 3'd2,
      NW_SLOT_TAIL = 3'd3,
      NW_P_SLOT    = 3'd4,
      NW_SLOT_SELF = 3'd5,
      NW_INIT      = 3'd6
   } nw_type;

   // prev link table write select
   typedef enum logic [2:0] {
      PW_NONE      = 3'd0,
      PW_UNLINK    = 3'd1,
      PW_SLOT_PREV = 3'd2,
      PW_TAIL_SLOT = 3'd3,
      PW_SLOT_SELF = 3'd4,
      PW_INIT      = 3'd5
   } pw_type;

   typedef enum logic [1:0] {
      TL_HOLD    = 2'd0,
      TL_ADVANCE = 2'd1,
      TL_SLOT    = 2'd2,
      TL_ONE     = 2'd3
   } tail_op_type;

   typedef struct packed {
      cond_type    cond;
      step_type    target;
      nw_type      nw;
      pw_type      pw;
      tail_op_type tail_op;
      logic        cap_links;
      logic        respond;
      status_type  status;
      logic        grant_tail;
   } ctl_word_type;

   typedef struct packed {
      logic tail_zero;
      logic bad_slot;
      logic loop_more;
   } flags_type;

   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type cw;
      cw = '0;
      cw.cond    = COND_NONE;
      cw.target  = S_IDLE;
      cw.nw      = NW_NONE;
      cw.pw      = PW_NONE;
      cw.tail_op = TL_HOLD;
      cw.status  = ST_OK;
      case (step)
         S_A_CHK: begin
            cw.cond   = COND_TAIL_ZERO;
            cw.target = S_R_EMPTY;
         end
         S_A_LINK: begin
            cw.nw        = NW_UNLINK;
            cw.pw        = PW_UNLINK;
            cw.cap_links = 1'b1;
         end
         S_A_TAIL: begin
            cw.nw         = NW_RING_END;
            cw.tail_op    = TL_ADVANCE;
            cw.respond    = 1'b1;
            cw.grant_tail = 1'b1;
         end
         S_F_CHK: begin
            cw.cond   = COND_BAD_SLOT;
            cw.target = S_R_BAD;
         end
         S_F_TEST: begin
            cw.cond   = COND_TAIL_ZERO;
            cw.target = S_F_SOLO;
         end
         S_F_LINK1: begin
            cw.nw        = NW_SLOT_TAIL;
            cw.pw        = PW_SLOT_PREV;
            cw.cap_links = 1'b1;
         end
         S_F_LINK2: begin
            cw.nw      = NW_P_SLOT;
            cw.pw      = PW_TAIL_SLOT;
            cw.respond = 1'b1;
         end
         S_F_SOLO: begin
            cw.nw      = NW_SLOT_SELF;
            cw.pw      = PW_SLOT_SELF;
            cw.tail_op = TL_SLOT;
            cw.respond = 1'b1;
         end
         S_I_LOOP: begin
            cw.nw     = NW_INIT;
            cw.pw     = PW_INIT;
            cw.cond   = COND_LOOP_MORE;
            cw.target = S_I_LOOP;
         end
         S_I_DONE: begin
            cw.tail_op = TL_ONE;
            cw.respond = 1'b1;
         end
         S_R_EMPTY: begin
            cw.respond = 1'b1;
            cw.status  = ST_EMPTY;
         end
         S_R_BAD: begin
            cw.respond = 1'b1;
            cw.status  = ST_BAD_SLOT;
         end
         S_R_OK: begin
            cw.respond = 1'b1;
         end
         default: begin
            cw.cond = COND_NONE;
         end
      endcase
      return cw;
   endfunction

   function automatic step_type entry_step(input mode_type mode);
      step_type s;
      case (mode)
         MODE_ALLOC: s = S_A_CHK;
         MODE_FREE:  s = S_F_CHK;
         MODE_INIT:  s = S_I_LOOP;
         default:    s = S_R_OK;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/sfla_link_ram.sv =====
// sfla_link_ram: one link table, one write port and one registered read port
// depends on sfla_pkg for the link type
`timescale 1ns / 1ps

module sfla_link_ram
   import sfla_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  link_type      wr_data,
   input  logic [AW-1:0] rd_addr,
   output link_type      rd_data
);

   link_type mem_ff [DEPTH];
   link_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read returns the old entry when written in the same cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sfla_sequencer.sv =====
// sfla_sequencer: step counter, control store lookup and conditional jumps
// depends on sfla_pkg for the control word, step codes and the control store
`timescale 1ns / 1ps

module sfla_sequencer
   import sfla_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  mode_type     mode,
   input  flags_type    flags,
   input  logic         go,
   output ctl_word_type cw,
   output logic         idle
);

   step_type upc_ff;
   step_type upc_in;
   logic     taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      cw = ucode(upc_ff);
      case (cw.cond)
         COND_TAIL_ZERO: taken = flags.tail_zero;
         COND_BAD_SLOT:  taken = flags.bad_slot;
         COND_LOOP_MORE: taken = flags.loop_more;
         default:        taken = 1'b0;
      endcase
      upc_in = upc_ff;
      if (upc_ff == S_IDLE) begin
         if (accept) begin
            upc_in = entry_step(mode);
         end
      end else if (go) begin
         if (cw.respond) begin
            upc_in = S_IDLE;
         end else if (taken) begin
            upc_in = cw.target;
         end else begin
            upc_in = step_type'(upc_ff + 4'd1);
         end
      end
   end

   assign idle = (upc_ff == S_IDLE);

endmodule

// ===== rtl/slot_free_list_allocator.sv =====
// slot free list allocator: ring of free slots kept in next and prev link tables plus a tail.
// a microcoded step sequence handles one request at a time; the step counter runs one control
// word per cycle unless a response step waits on a full output register. allocate: check,
// link, tail, or check, empty response. free: check, test, link1, link2, or check, test, solo
// for an empty list, or check, bad response for an invalid slot. initialize: loop over slots
// 1 to count-1, then done. unused mode: ok response. requests are taken only while the
// sequencer is idle; registered table reads and one write port per table set the pace.
// reset: tail cleared (list empty), slot count 64; link tables hold no reset value.
`timescale 1ns / 1ps

module slot_free_list_allocator
   import sfla_pkg::*;
#(
   parameter int MAX_SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   // request
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [5:0] slot_to_free, [7:6] zero
   input  logic [1:0]        req_tuser,   // [1:0] mode
   // response
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [5:0] granted_slot, [7:6] zero
   output logic [1:0]        rsp_tuser,   // [1:0] status
   // csr
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_W-1:0]  csr_pwdata,
   output logic [CSR_W-1:0]  csr_prdata,
   output logic              csr_pready
);

   localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int LIM = (MAX_SLOTS < LINK_SPAN) ? MAX_SLOTS : LINK_SPAN;

   ctl_word_type cw;
   flags_type    flags;
   logic         seq_idle;
   logic         req_accept;
   logic         go;

   count_type    slot_count_ff;
   count_type    live_cnt;
   link_type     c_m1;

   link_type     tail_ff;
   link_type     tail_in;
   link_type     slot_ff;
   link_type     n_ff;
   link_type     p_ff;
   link_type     i_ff;

   link_type     next_q;
   link_type     prev_q;
   logic [AW-1:0] rd_addr;

   logic          nw_en;
   logic [AW-1:0] nw_addr;
   link_type      nw_data;
   logic          pw_en;
   logic [AW-1:0] pw_addr;
   link_type      pw_data;

   logic          rsp_tvalid_ff;
   link_type      rsp_grant_ff;
   status_type    rsp_status_ff;

   // link values outside the table fall back to slot zero
   function automatic logic [AW-1:0] ix(input link_type v);
      logic [AW-1:0] r;
      r = '0;
      if (32'(v) < MAX_SLOTS) begin
         r = AW'(32'(v));
      end
      return r;
   endfunction

   // ---------------- csr ----------------
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SLOT_COUNT) ? CSR_W'(slot_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_SLOT_COUNT) begin
         slot_count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      if (slot_count_ff < 7'd2) begin
         live_cnt = 7'd2;
      end else if (32'(slot_count_ff) > LIM) begin
         live_cnt = COUNT_W'(LIM);
      end else begin
         live_cnt = slot_count_ff;
      end
      c_m1 = LINK_W'(live_cnt - 7'd1);
   end

   // ---------------- sequencer ----------------
   assign req_tready = seq_idle;
   assign req_accept = req_tvalid && req_tready;

   // a response step waits while the output register is still full and the receiver is not ready
   assign go = !(cw.respond && rsp_tvalid_ff && !rsp_tready);

   assign flags.tail_zero = (tail_ff == '0);
   assign flags.bad_slot  = (slot_ff == '0) || ({1'b0, slot_ff} >= live_cnt);
   assign flags.loop_more = (i_ff != c_m1);

   sfla_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .mode   (mode_type'(req_tuser)),
      .flags  (flags),
      .go     (go),
      .cw     (cw),
      .idle   (seq_idle)
   );

   // ---------------- link tables ----------------
   // both tables are only ever read at the tail
   assign rd_addr = ix(tail_ff);

   always_comb begin
      nw_en   = 1'b1;
      nw_addr = '0;
      nw_data = '0;
      case (cw.nw)
         NW_UNLINK: begin
            nw_addr = ix(prev_q);
            nw_data = next_q;
         end
         NW_RING_END: begin
            nw_en   = (n_ff == tail_ff);
            nw_addr = ix(tail_ff);
         end
         NW_SLOT_TAIL: begin
            nw_addr = ix(slot_ff);
            nw_data = tail_ff;
         end
         NW_P_SLOT: begin
            nw_addr = ix(p_ff);
            nw_data = slot_ff;
         end
         NW_SLOT_SELF: begin
            nw_addr = ix(slot_ff);
            nw_data = slot_ff;
         end
         NW_INIT: begin
            nw_addr = ix(i_ff);
            nw_data = (i_ff == c_m1) ? 6'd1 : i_ff + 6'd1;
         end
         default: begin
            nw_en = 1'b0;
         end
      endcase
      nw_en = nw_en && go;
   end

   always_comb begin
      pw_en   = 1'b1;
      pw_addr = '0;
      pw_data = '0;
      case (cw.pw)
         PW_UNLINK: begin
            pw_addr = ix(next_q);
            pw_data = prev_q;
         end
         PW_SLOT_PREV: begin
            pw_addr = ix(slot_ff);
            pw_data = prev_q;
         end
         PW_TAIL_SLOT: begin
            pw_addr = ix(tail_ff);
            pw_data = slot_ff;
         end
         PW_SLOT_SELF: begin
            pw_addr = ix(slot_ff);
            pw_data = slot_ff;
         end
         PW_INIT: begin
            pw_addr = ix(i_ff);
            pw_data = (i_ff == 6'd1) ? c_m1 : i_ff - 6'd1;
         end
         default: begin
            pw_en = 1'b0;
         end
      endcase
      pw_en = pw_en && go;
   end

   sfla_link_ram #(.DEPTH(MAX_SLOTS), .AW(AW)) u_next (
      .clock   (clock),
      .wr_en   (nw_en),
      .wr_addr (nw_addr),
      .wr_data (nw_data),
      .rd_addr (rd_addr),
      .rd_data (next_q)
   );

   sfla_link_ram #(.DEPTH(MAX_SLOTS), .AW(AW)) u_prev (
      .clock   (clock),
      .wr_en   (pw_en),
      .wr_addr (pw_addr),
      .wr_data (pw_data),
      .rd_addr (rd_addr),
      .rd_data (prev_q)
   );

   // ---------------- datapath registers ----------------
   always_comb begin
      case (cw.tail_op)
         TL_ADVANCE: tail_in = (n_ff == tail_ff) ? '0 : n_ff;
         TL_SLOT:    tail_in = slot_ff;
         TL_ONE:     tail_in = 6'd1;
         default:    tail_in = tail_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= '0;
      end else if (go) begin
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         slot_ff <= req_tdata[LINK_W-1:0];
      end
      if (req_accept) begin
         i_ff <= 6'd1;
      end else if (go && cw.nw == NW_INIT) begin
         i_ff <= i_ff + 6'd1;
      end
      if (go && cw.cap_links) begin
         n_ff <= next_q;
         p_ff <= prev_q;
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (go && cw.respond) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && cw.respond) begin
         rsp_grant_ff  <= cw.grant_tail ? tail_ff : '0;
         rsp_status_ff <= cw.status;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_grant_ff};
   assign rsp_tuser  = rsp_status_ff;

   // ---------------- assertions ----------------
   a_resp_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (cw.respond && go) |=> seq_idle)
      else $error("sequencer did not return to idle after a response");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      seq_idle |-> (!nw_en && !pw_en))
      else $error("link table written while idle");

   a_init_index_range: assert property (@(posedge clock) disable iff (reset)
      (cw.nw == NW_INIT) |-> (i_ff != '0 && i_ff <= c_m1))
      else $error("ring init index out of range");

   a_empty_no_grant: assert property (@(posedge clock) disable iff (reset)
      (go && cw.respond && cw.status == ST_EMPTY) |=> (rsp_grant_ff == '0))
      else $error("empty response carries a slot");

endmodule
